// ===== src/msf_pkg.sv =====
// Shared types and constants for the monochrome span fill core.
// Used by msf_rem, msf_dp, msf_ctrl and mono_span_fill_pattern_core.
// No dependencies.
package msf_pkg;

	localparam int MAX_ROW_BYTES = 32;
	localparam int MAX_ROWS      = 128;
	localparam int PATTERN_DEPTH = 8;

	localparam int ADDR_W = 12;      // byte address
	localparam int COL_W  = 6;       // byte column, covers up to 64 bytes per row
	localparam int EP_W   = COL_W + 3; // pixel column
	localparam int SUM_W  = 11;      // room for x + len and row limits
	localparam int RB_W   = 6;       // row_bytes register
	localparam int PH_W   = 4;       // pattern_height register
	localparam int MAG_W  = 8;       // |y - origin_y|
	localparam int REM_W  = 3;       // pattern row index

	localparam int IN_W   = 48;
	localparam int OUT_W  = 32;
	localparam int CIDX_W = 3;
	localparam int CDAT_W = 64;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_PATTERN_ENABLE = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_PATTERN_FIXED  = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_PATTERN_HEIGHT = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_PATTERN_ROWS   = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_DRAW_COLOR     = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_DRAW_MODE      = 3'd5;
	localparam logic [CIDX_W-1:0] CFG_ROW_BYTES      = 3'd6;

	typedef struct packed {
		logic            pattern_enable;
		logic            pattern_fixed;
		logic [PH_W-1:0] pattern_height;
		logic [63:0]     pattern_rows;
		logic            draw_color;
		logic            draw_mode;
		logic [RB_W-1:0] row_bytes;
	} msf_cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic prep;
		logic div_start;
		logic line;
		logic emit;
	} msf_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic use_pat;
		logic div_done;
		logic out_free;
		logic at_end;
	} msf_sts_t;

endpackage

// ===== src/msf_rem.sv =====
// Bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle.
// Depends on msf_pkg.
module msf_rem import msf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MAG_W-1:0] dividend,
	input  logic [PH_W-1:0]  divisor,
	output logic             done,
	output logic [REM_W-1:0] rem
);

	logic [MAG_W-1:0] dvd_q;
	logic [PH_W-1:0]  dvs_q;
	logic [REM_W-1:0] rem_q;
	logic [2:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [PH_W-1:0]  trial;
	logic [PH_W-1:0]  diff;

	assign trial = {rem_q, dvd_q[MAG_W-1]};
	assign diff  = trial - dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'(MAG_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= (trial >= dvs_q) ? diff[REM_W-1:0] : trial[REM_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ({1'b0, rem_q} < dvs_q))
		else $error("remainder not below divisor");

	a_busy_done_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && done_q))
		else $error("remainder unit busy and done together");

endmodule

// ===== src/msf_dp.sv =====
// Span fill datapath: span setup, pattern row select and rotate, byte walk,
// output register. Depends on msf_pkg and msf_rem.
module msf_dp import msf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  msf_cfg_t         cfg,
	input  msf_cmd_t         cmd,
	output msf_sts_t         sts,
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,
	output logic             m_tlast,
	output logic             m_tuser
);

	// input fields
	logic [7:0]       in_x;
	logic [6:0]       in_y;
	logic [8:0]       in_len;
	logic [8:0]       in_px;
	logic [7:0]       in_py;

	// setup logic
	logic [RB_W-1:0]  rb_eff;
	logic [PH_W-1:0]  ph_eff;
	logic [SUM_W-1:0] rowpix;
	logic [SUM_W-1:0] ep_raw;
	logic [SUM_W-1:0] ep_lim;
	logic [SUM_W-1:0] ep_clip;
	logic             empty_d;
	logic             use_pat_d;
	logic [8:0]       px_eff;
	logic [7:0]       py_eff;
	logic signed [9:0] dy;
	logic [9:0]       dy_abs;
	logic [12:0]      base_prod;

	// stored span
	logic [ADDR_W-1:0] base_q;
	logic [COL_W-1:0]  b0_q;
	logic [COL_W-1:0]  b1_q;
	logic [2:0]        x_lo_q;
	logic [2:0]        ep_lo_q;
	logic [2:0]        k_q;
	logic [PH_W-1:0]   ph_q;
	logic [MAG_W-1:0]  mag_q;
	logic              neg_q;
	logic              use_pat_q;
	logic              empty_q;

	// walk
	logic [ADDR_W-1:0] cursor_q;
	logic [ADDR_W-1:0] end_q;
	logic [7:0]        line_q;
	logic              first_q;

	logic              div_done;
	logic [REM_W-1:0]  rem;
	logic [REM_W-1:0]  idx;
	logic [7:0]        row;
	logic [15:0]       rot;
	logic [7:0]        mask;
	logic              at_end;

	// output register
	logic              ovalid_q;
	logic [ADDR_W-1:0] oaddr_q;
	logic [7:0]        omask_q;
	logic [7:0]        oval_q;
	logic              oop_q;
	logic              olast_q;

	assign in_x   = s_tdata[7:0];
	assign in_y   = s_tdata[14:8];
	assign in_len = s_tdata[23:15];
	assign in_px  = s_tdata[32:24];
	assign in_py  = s_tdata[40:33];

	always_comb begin
		if (cfg.row_bytes == '0)
			rb_eff = RB_W'(1);
		else if (int'(cfg.row_bytes) > MAX_ROW_BYTES)
			rb_eff = RB_W'(MAX_ROW_BYTES);
		else
			rb_eff = cfg.row_bytes;

		if (cfg.pattern_height == '0)
			ph_eff = PH_W'(1);
		else if (int'(cfg.pattern_height) > PATTERN_DEPTH)
			ph_eff = PH_W'(PATTERN_DEPTH);
		else
			ph_eff = cfg.pattern_height;
	end

	assign rowpix  = SUM_W'({rb_eff, 3'b000});
	assign ep_raw  = SUM_W'(in_x) + SUM_W'(in_len) - SUM_W'(1);
	assign ep_lim  = rowpix - SUM_W'(1);
	assign ep_clip = (ep_raw > ep_lim) ? ep_lim : ep_raw;
	assign empty_d = (in_len == '0) || (SUM_W'(in_x) >= rowpix) ||
	                 (SUM_W'(in_y) >= SUM_W'(MAX_ROWS));

	// origin x of all ones (-1) means no pattern; tested before the fixed origin
	assign use_pat_d = cfg.pattern_enable && (in_px != 9'h1FF);
	assign px_eff    = cfg.pattern_fixed ? '0 : in_px;
	assign py_eff    = cfg.pattern_fixed ? '0 : in_py;
	assign dy        = $signed({3'b000, in_y}) - $signed({{2{py_eff[7]}}, py_eff});
	assign dy_abs    = dy[9] ? 10'(-dy) : 10'(dy);
	assign base_prod = 13'(in_y) * 13'(rb_eff);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q    <= base_prod[ADDR_W-1:0];
			b0_q      <= COL_W'(in_x[7:3]);
			b1_q      <= ep_clip[EP_W-1:3];
			x_lo_q    <= in_x[2:0];
			ep_lo_q   <= ep_clip[2:0];
			k_q       <= in_x[2:0] + in_x[2:0] - px_eff[2:0];
			ph_q      <= ph_eff;
			mag_q     <= dy_abs[MAG_W-1:0];
			neg_q     <= dy[9];
			use_pat_q <= use_pat_d;
			empty_q   <= empty_d;
		end
	end

	msf_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (mag_q),
		.divisor  (ph_q),
		.done     (div_done),
		.rem      (rem)
	);

	// C-style remainder folded into 0..ph-1
	always_comb begin
		logic [PH_W-1:0] wrapped;
		wrapped = ph_q - PH_W'(rem);
		idx = (neg_q && rem != '0) ? wrapped[REM_W-1:0] : rem;
	end

	assign row = cfg.pattern_rows[{idx, 3'b000} +: 8];
	assign rot = {row, row} << k_q;

	assign at_end = (cursor_q == end_q);

	always_comb begin
		mask = line_q;
		if (first_q)
			mask = mask & (8'hFF << x_lo_q);
		if (at_end)
			mask = mask & (8'hFF >> (3'd7 - ep_lo_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			end_q    <= '0;
			line_q   <= '0;
			first_q  <= 1'b0;
		end else begin
			if (cmd.prep) begin
				cursor_q <= base_q + ADDR_W'(b0_q);
				end_q    <= base_q + ADDR_W'(b1_q);
				first_q  <= 1'b1;
			end else if (cmd.emit) begin
				cursor_q <= cursor_q + ADDR_W'(1);
				first_q  <= 1'b0;
			end
			if (cmd.line)
				line_q <= use_pat_q ? rot[15:8] : 8'hFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovalid_q <= 1'b0;
		else if (cmd.emit)
			ovalid_q <= 1'b1;
		else if (m_tready)
			ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			oaddr_q <= cursor_q;
			omask_q <= mask;
			oval_q  <= cfg.draw_color ? mask : 8'h00;
			oop_q   <= cfg.draw_mode;
			olast_q <= at_end;
		end
	end

	assign sts.empty    = empty_q;
	assign sts.use_pat  = use_pat_q;
	assign sts.div_done = div_done;
	assign sts.out_free = !ovalid_q || m_tready;
	assign sts.at_end   = at_end;

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {4'b0000, oval_q, omask_q, oaddr_q};
	assign m_tlast  = olast_q;
	assign m_tuser  = oop_q;

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.prep && !empty_q) |-> (b1_q >= b0_q))
		else $error("clipped span ends before it starts");

endmodule

// ===== src/msf_ctrl.sv =====
// Span fill controller: accept, setup, pattern row remainder wait, byte walk.
// Depends on msf_pkg.
module msf_ctrl import msf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  msf_sts_t sts,
	output msf_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_LINE = 3'd3;
	localparam logic [2:0] ST_RUN  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		s_tready      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				if (sts.empty)
					state_d = ST_IDLE;
				else if (sts.use_pat) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else
					state_d = ST_LINE;
			end
			ST_DIV: begin
				if (sts.div_done)
					state_d = ST_LINE;
			end
			ST_LINE: begin
				cmd.line = 1'b1;
				state_d  = ST_RUN;
			end
			ST_RUN: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.at_end)
						state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	a_line_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LINE) |-> ($past(state_q) == ST_PREP || $past(state_q) == ST_DIV))
		else $error("pattern line latched without setup");

endmodule

// ===== src/mono_span_fill_pattern_core.sv =====
// Monochrome span fill core: one span item in, one masked byte write per touched byte out.
// After accept, an item passes setup, then the bit-serial pattern row remainder when the pattern is applied,
// then the pattern line latch and the byte walk; the walk emits one byte per cycle while the output is free,
// and stalls while it is held; the input is taken only when idle.
// Reset (arst_n low, asynchronous): controller idle, output empty, configuration registers at defaults.
// Depends on msf_pkg, msf_ctrl, msf_dp (with msf_rem).
module mono_span_fill_pattern_core import msf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,   // span_x, span_y, span_len, pat_origin_x, pat_origin_y
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // byte_address, write_mask, write_value
	output logic              m_tlast,
	output logic              m_tuser,   // combine_op
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CDAT_W-1:0] cfg_data
);

	msf_cfg_t cfg_q;
	msf_cmd_t cmd;
	msf_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_enable <= 1'b0;
			cfg_q.pattern_fixed  <= 1'b0;
			cfg_q.pattern_height <= PH_W'(8);
			cfg_q.pattern_rows   <= '0;
			cfg_q.draw_color     <= 1'b0;
			cfg_q.draw_mode      <= 1'b0;
			cfg_q.row_bytes      <= RB_W'(32);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PATTERN_ENABLE: cfg_q.pattern_enable <= cfg_data[0];
				CFG_PATTERN_FIXED:  cfg_q.pattern_fixed  <= cfg_data[0];
				CFG_PATTERN_HEIGHT: cfg_q.pattern_height <= cfg_data[PH_W-1:0];
				CFG_PATTERN_ROWS:   cfg_q.pattern_rows   <= cfg_data;
				CFG_DRAW_COLOR:     cfg_q.draw_color     <= cfg_data[0];
				CFG_DRAW_MODE:      cfg_q.draw_mode      <= cfg_data[0];
				CFG_ROW_BYTES:      cfg_q.row_bytes      <= cfg_data[RB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	msf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	msf_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
